// File: design/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_policy_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_ALLOC = 1'b1
  } action_e;

  localparam logic CFG_FIT_POLICY    = 1'b0;
  localparam logic CFG_BLOCKS_IN_USE = 1'b1;

  localparam int CFG_DATA_W   = 5;
  localparam int INDEX_PORT_W = 4;
  localparam int SIZE_PORT_W  = 16;

  localparam int BLOCKS_DEF    = 16;
  localparam int SIZE_BITS_DEF = 16;

  localparam fit_policy_e      POLICY_RST        = FIT_FIRST;
  localparam logic [CFG_DATA_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

endpackage

// File: design/pfa_cell.sv
`timescale 1ns / 1ps

module pfa_cell import pfa_pkg::*; #(
  parameter int  BLOCKS    = BLOCKS_DEF,
  parameter int  SIZE_BITS = SIZE_BITS_DEF,
  parameter int  CELL_IDX  = 0,
  parameter type tok_t     = logic,
  parameter type ctl_t     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t ctl_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_W = $clog2(BLOCKS + 1);

  logic [SIZE_BITS-1:0] free_q;
  tok_t                 tok_d, tok_q;
  logic                 in_scan, fits, upper, better;

  always_comb begin
    in_scan = CNT_W'(CELL_IDX) < ctl_i.scan_len;
    fits    = in_scan && (ctl_i.want <= free_q);
    upper   = IDX_W'(CELL_IDX) >= ctl_i.start;
    case (ctl_i.policy)
      FIT_BEST:  better = free_q < tok_i.val;
      FIT_WORST: better = free_q > tok_i.val;
      FIT_NEXT:  better = upper && !tok_i.upper;
      default:   better = 1'b0;
    endcase
    tok_d = tok_i;
    if (fits && (!tok_i.hit || better)) begin
      tok_d.hit   = 1'b1;
      tok_d.idx   = IDX_W'(CELL_IDX);
      tok_d.val   = free_q;
      tok_d.upper = upper;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // table entry, written by a load or by the winning grant
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_en && (ctl_i.load_idx == IDX_W'(CELL_IDX))) begin
      free_q <= ctl_i.load_val;
    end else if (ctl_i.commit_en && (ctl_i.commit_idx == IDX_W'(CELL_IDX))) begin
      free_q <= free_q - ctl_i.want;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: design/partition_fit_allocator_unit.sv
// Partition fit allocator: a table of free sizes for up to BLOCKS memory blocks.
// Input channel (in_valid_i / in_stall_o): a load request writes one block's
// free size, an allocation request asks for amount_i under the fit policy.
// Output channel (out_valid_o / out_stall_i): one result per request with
// granted_o, chosen_block_o and space_left_o; a miss gives all zeros.
// Configuration: cfg_we_i writes fit_policy (index 0) or blocks_in_use
// (index 1); write only while the block is idle.
// An allocation request sends a search token down a row of BLOCKS cells, one
// cell per cycle, each cell holding one table entry. The result from the last
// cell goes to the holding stage and then to the output register; no new
// request is taken until the result has moved to the output. A load goes
// straight to the holding stage without a scan.
// The finished result waits in a holding stage while the receiver stalls; the
// table update of a grant is applied when the result moves to the output.
// Reset clears the policy to first fit, blocks_in_use to 16 and the next-fit
// pointer to 0; table entries hold nothing until loaded.
`timescale 1ns / 1ps

module partition_fit_allocator_unit import pfa_pkg::*; #(
  parameter int BLOCKS    = BLOCKS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    action_i,
  input  logic [INDEX_PORT_W-1:0] load_index_i,
  input  logic [SIZE_PORT_W-1:0]  amount_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    granted_o,
  output logic [INDEX_PORT_W-1:0] chosen_block_o,
  output logic [SIZE_PORT_W-1:0]  space_left_o
);

  localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_W = $clog2(BLOCKS + 1);

  typedef struct packed {
    logic                 act;
    logic                 hit;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] val;
    logic                 upper;
  } tok_t;

  typedef struct packed {
    fit_policy_e          policy;
    logic [CNT_W-1:0]     scan_len;
    logic [IDX_W-1:0]     start;
    logic [SIZE_BITS-1:0] want;
    logic                 load_en;
    logic [IDX_W-1:0]     load_idx;
    logic [SIZE_BITS-1:0] load_val;
    logic                 commit_en;
    logic [IDX_W-1:0]     commit_idx;
  } ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                state_q, state_d;
  fit_policy_e           policy_q;
  logic [CFG_DATA_W-1:0] blocks_in_use_q;
  logic [IDX_W-1:0]      next_start_q;
  logic                  go_q;
  logic [SIZE_BITS-1:0]  want_q;
  logic                  res_alloc_q, res_hit_q;
  logic [IDX_W-1:0]      res_idx_q;
  logic [SIZE_BITS-1:0]  res_val_q;
  logic                  out_valid_q, granted_q;
  logic [INDEX_PORT_W-1:0] chosen_q;
  logic [SIZE_PORT_W-1:0]  space_q;

  logic                  accept, accept_alloc, load_ok, out_free, emit;
  logic [SIZE_BITS-1:0]  amount_w;
  logic [CNT_W-1:0]      scan_len;
  logic [IDX_W-1:0]      start_eff;
  ctl_t                  ctl;
  tok_t                  tok_chain [BLOCKS+1];
  tok_t                  last_tok;
  logic [BLOCKS-1:0]     act_vec;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign accept_alloc = accept && (action_e'(action_i) == ACT_ALLOC);
  assign load_ok      = 32'(load_index_i) < BLOCKS;
  assign amount_w     = SIZE_BITS'(amount_i);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign emit         = (state_q == ST_DONE) && out_free;
  assign last_tok     = tok_chain[BLOCKS];

  assign scan_len  = (32'(blocks_in_use_q) < BLOCKS) ? CNT_W'(blocks_in_use_q)
                                                      : CNT_W'(BLOCKS);
  assign start_eff = (CNT_W'(next_start_q) < scan_len) ? next_start_q : '0;

  always_comb begin
    ctl.policy     = policy_q;
    ctl.scan_len   = scan_len;
    ctl.start      = start_eff;
    ctl.want       = want_q;
    ctl.load_en    = accept && (action_e'(action_i) == ACT_LOAD) && load_ok;
    ctl.load_idx   = IDX_W'(load_index_i);
    ctl.load_val   = amount_w;
    ctl.commit_en  = emit && res_alloc_q && res_hit_q;
    ctl.commit_idx = res_idx_q;
  end

  always_comb begin
    tok_chain[0]       = '0;
    tok_chain[0].act   = go_q;
  end

  for (genvar i = 0; i < BLOCKS; i++) begin : g_cell
    pfa_cell #(
      .BLOCKS    (BLOCKS),
      .SIZE_BITS (SIZE_BITS),
      .CELL_IDX  (i),
      .tok_t     (tok_t),
      .ctl_t     (ctl_t)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .tok_i  (tok_chain[i]),
      .tok_o  (tok_chain[i+1])
    );
    assign act_vec[i] = tok_chain[i+1].act;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = accept_alloc ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_tok.act) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      policy_q        <= POLICY_RST;
      blocks_in_use_q <= BLOCKS_IN_USE_RST;
      next_start_q    <= '0;
      go_q            <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= accept_alloc;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FIT_POLICY:    policy_q <= fit_policy_e'(cfg_wdata_i[1:0]);
          CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (ctl.commit_en) begin
        next_start_q <= res_idx_q;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pending result and request payload
  always_ff @(posedge clk_i) begin
    if (accept_alloc) begin
      want_q      <= amount_w;
      res_alloc_q <= 1'b1;
    end else if (accept) begin
      res_alloc_q <= 1'b0;
      res_hit_q   <= load_ok;
      res_idx_q   <= IDX_W'(load_index_i);
      res_val_q   <= amount_w;
    end
    if ((state_q == ST_SCAN) && last_tok.act) begin
      res_hit_q <= last_tok.hit;
      res_idx_q <= last_tok.idx;
      res_val_q <= last_tok.val - want_q;
    end
    if (emit) begin
      granted_q <= res_hit_q;
      chosen_q  <= res_hit_q ? INDEX_PORT_W'(res_idx_q) : '0;
      space_q   <= res_hit_q ? SIZE_PORT_W'(res_val_q) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign chosen_block_o = chosen_q;
  assign space_left_o   = space_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(act_vec))
    else $error("more than one search token in the cell row");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_vec != '0) |-> (state_q == ST_SCAN))
    else $error("search token outside of a scan");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result shown without a finished request");

  a_commit_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit_en |-> (res_alloc_q && !ctl.load_en))
    else $error("table update without an allocation");

endmodule

// File: tb/partition_fit_checker.sv
`timescale 1ns / 1ps

module partition_fit_checker import pfa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    action_i,
  input  logic [INDEX_PORT_W-1:0] load_index_i,
  input  logic [SIZE_PORT_W-1:0]  amount_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic                    granted_i,
  input  logic [INDEX_PORT_W-1:0] chosen_block_i,
  input  logic [SIZE_PORT_W-1:0]  space_left_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  typedef struct packed {
    logic                    granted;
    logic [INDEX_PORT_W-1:0] block;
    logic [SIZE_PORT_W-1:0]  left;
  } grant_t;

  logic [SIZE_PORT_W-1:0]  free_space [BLOCKS_DEF];
  logic [INDEX_PORT_W-1:0] next_fit_start;
  fit_policy_e             policy;
  logic [CFG_DATA_W-1:0]   blocks_in_use;
  grant_t                  grants_due [$];
  int unsigned             failures = 0;

  function automatic grant_t place_item(input action_e act,
                                        input logic [INDEX_PORT_W-1:0] idx,
                                        input logic [SIZE_PORT_W-1:0] amt);
    grant_t r;
    int     span;
    int     pos;
    int     pick;
    int     j;
    r = '0;
    if (act == ACT_LOAD) begin
      if (idx < BLOCKS_DEF) begin
        free_space[idx] = amt;
        r.granted = 1'b1;
        r.block   = idx;
        r.left    = amt;
      end
      return r;
    end
    span = (blocks_in_use < BLOCKS_DEF) ? int'(blocks_in_use) : BLOCKS_DEF;
    pick = -1;
    if (policy == FIT_NEXT) begin
      pos = (next_fit_start < span) ? int'(next_fit_start) : 0;
      for (j = 0; j < span; j++) begin
        if (pick < 0 && amt <= free_space[pos]) pick = pos;
        pos = (pos + 1 == span) ? 0 : pos + 1;
      end
    end else begin
      for (j = 0; j < span; j++) begin
        if (amt <= free_space[j]) begin
          if (pick < 0 ||
              (policy == FIT_BEST && free_space[j] < free_space[pick]) ||
              (policy == FIT_WORST && free_space[j] > free_space[pick]))
            pick = j;
        end
      end
    end
    if (pick >= 0) begin
      free_space[pick] = free_space[pick] - amt;
      next_fit_start   = pick[INDEX_PORT_W-1:0];
      r.granted        = 1'b1;
      r.block          = pick[INDEX_PORT_W-1:0];
      r.left           = free_space[pick];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    grant_t got;
    if (!rst_ni) begin
      for (int i = 0; i < BLOCKS_DEF; i++) free_space[i] = '0;
      next_fit_start = '0;
      policy         = POLICY_RST;
      blocks_in_use  = BLOCKS_IN_USE_RST;
      grants_due.delete();
      pending_o    <= 0;
      fail_count_o <= failures;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FIT_POLICY) policy = fit_policy_e'(cfg_wdata_i[1:0]);
        else blocks_in_use = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{granted_i, chosen_block_i, space_left_i};
        if (grants_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: granted=%0d block=%0d left=%0d",
                     got.granted, got.block, got.left);
        end else begin
          want = grants_due.pop_front();
          if (got.granted !== want.granted || got.block !== want.block ||
              got.left !== want.left) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected granted=%0d block=%0d left=%0d, got %0d %0d %0d",
                       want.granted, want.block, want.left,
                       got.granted, got.block, got.left);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        grants_due.push_back(place_item(action_e'(action_i), load_index_i, amount_i));
      pending_o    <= grants_due.size();
      fail_count_o <= failures;
    end
  end

endmodule

// File: tb/partition_fit_allocator_unit_test.sv
`timescale 1ns / 1ps

module partition_fit_allocator_unit_test;
  import pfa_pkg::*;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic                    cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    action = 1'b0;
  logic [INDEX_PORT_W-1:0] load_index = '0;
  logic [SIZE_PORT_W-1:0]  amount = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    granted;
  logic [INDEX_PORT_W-1:0] chosen_block;
  logic [SIZE_PORT_W-1:0]  space_left;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  bit          idling_on = 1'b1;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  partition_fit_allocator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .load_index_i  (load_index),
    .amount_i      (amount),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .granted_o     (granted),
    .chosen_block_o(chosen_block),
    .space_left_o  (space_left)
  );

  partition_fit_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .action_i      (action),
    .load_index_i  (load_index),
    .amount_i      (amount),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .granted_i     (granted),
    .chosen_block_i(chosen_block),
    .space_left_i  (space_left),
    .fail_count_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  // receiver side: random stall bursts and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_done = 1'b1;
      stall_left = 300;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(input action_e act, input logic [INDEX_PORT_W-1:0] idx,
                              input logic [SIZE_PORT_W-1:0] amt);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    action     <= act;
    load_index <= idx;
    amount     <= amt;
    in_valid   <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (BLOCKS_DEF + 8) @(posedge clk_i);
  endtask

  task automatic write_config(input fit_policy_e pol, input logic [CFG_DATA_W-1:0] span);
    drain_requests();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIT_POLICY;
    cfg_wdata <= CFG_DATA_W'(pol);
    @(posedge clk_i);
    cfg_index <= CFG_BLOCKS_IN_USE;
    cfg_wdata <= span;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned            kind;
    logic [SIZE_PORT_W-1:0] amt;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      case ($urandom_range(0, 7))
        0:       amt = '0;
        1:       amt = '1;
        default: amt = SIZE_PORT_W'($urandom);
      endcase
      send_request(ACT_LOAD, INDEX_PORT_W'($urandom_range(0, 15)), amt);
    end else begin
      case ($urandom_range(0, 9))
        0:       amt = '0;
        1:       amt = '1;
        2, 3, 4: amt = SIZE_PORT_W'($urandom_range(0, 255));
        5, 6:    amt = SIZE_PORT_W'($urandom_range(0, 4095));
        default: amt = SIZE_PORT_W'($urandom);
      endcase
      send_request(ACT_ALLOC, INDEX_PORT_W'($urandom_range(0, 15)), amt);
    end
  endtask

  initial begin
    logic [SIZE_PORT_W-1:0] sizes [BLOCKS_DEF];
    fit_policy_e            pol;
    logic [CFG_DATA_W-1:0]  span;
    int unsigned            phase;
    int unsigned            len;
    sizes = '{16'h0000, 16'hFFFF, 16'h0010, 16'h0200, 16'h5555, 16'hAAAA, 16'h0040,
              16'h0040, 16'h1234, 16'h0008, 16'h8000, 16'h7FFF, 16'h0100, 16'h0020,
              16'h0001, 16'hFFFF};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every table entry once
    for (int i = 0; i < BLOCKS_DEF; i++)
      send_request(ACT_LOAD, INDEX_PORT_W'(i), sizes[i]);
    // zero size, full size, miss
    send_request(ACT_ALLOC, 4'hF, 16'h0000);
    send_request(ACT_ALLOC, 4'h0, 16'hFFFF);
    send_request(ACT_ALLOC, 4'h5, 16'hFFFF);
    send_request(ACT_ALLOC, 4'hA, 16'hFFFF);
    // stale next-fit pointer restarts at block zero
    write_config(FIT_NEXT, 5'd4);
    send_request(ACT_ALLOC, 4'h3, 16'h0001);
    send_request(ACT_ALLOC, 4'h3, 16'h0010);
    // scan length above the table size, tie on smallest
    write_config(FIT_BEST, 5'd31);
    send_request(ACT_ALLOC, 4'h0, 16'h0008);
    send_request(ACT_ALLOC, 4'h0, 16'h0040);
    write_config(FIT_WORST, 5'd16);
    send_request(ACT_ALLOC, 4'h0, 16'h0001);
    // empty scan misses everything
    write_config(FIT_FIRST, 5'd0);
    send_request(ACT_ALLOC, 4'h0, 16'h0000);

    phase = 0;
    while (items_sent < 850) begin
      pol = fit_policy_e'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0:       span = 5'd1;
        1:       span = 5'd16;
        2:       span = 5'd0;
        3:       span = CFG_DATA_W'($urandom_range(17, 31));
        default: span = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      write_config(pol, span);
      if (phase == 2) hold_off_req = 1'b1;
      len = $urandom_range(30, 80);
      repeat (len) begin
        if (items_sent > 750) idling_on = 1'b0;
        random_request();
      end
      phase++;
    end

    drain_requests();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/pfa_pkg.sv
design/pfa_cell.sv
design/partition_fit_allocator_unit.sv
tb/partition_fit_checker.sv
tb/partition_fit_allocator_unit_test.sv
